### hw/rtl/flight_phase_safety_sequencer_defines.svh
// ----------------------------------------------------------------------------
// flight_phase_safety_sequencer_defines.svh
// assertion macros shared by the flight phase sequencer rtl
// ----------------------------------------------------------------------------
`ifndef FLIGHT_PHASE_SAFETY_SEQUENCER_DEFINES_SVH
`define FLIGHT_PHASE_SAFETY_SEQUENCER_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define FPSS_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fpss assertion failed");

// property whose consequent must hold in the cycle after the antecedent
`define FPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpss assertion failed");

`endif

### hw/rtl/fpss_pkg.sv
// ----------------------------------------------------------------------------
// fpss_pkg
// types, codes and constants of the flight phase safety sequencer
// ----------------------------------------------------------------------------
package fpss_pkg;

    // width of the wrapping millisecond time base
    localparam int TIME_W = 32;
    // width used to compare elapsed time against the timer registers, up to 32 bits wide
    localparam int CMP_W  = (TIME_W > 32) ? TIME_W : 32;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    typedef logic [TIME_W-1:0] time_t;

    // phase state, one-hot
    typedef enum logic [5:0] {
        PH_BOOT      = 6'b000001,
        PH_READY     = 6'b000010,
        PH_ARMING    = 6'b000100,
        PH_HOVERING  = 6'b001000,
        PH_DISARMING = 6'b010000,
        PH_HALTED    = 6'b100000
    } phase_t;

    // external phase codes
    localparam logic [2:0] PHASE_CODE_BOOT      = 3'd0;
    localparam logic [2:0] PHASE_CODE_READY     = 3'd1;
    localparam logic [2:0] PHASE_CODE_ARMING    = 3'd2;
    localparam logic [2:0] PHASE_CODE_HOVERING  = 3'd3;
    localparam logic [2:0] PHASE_CODE_DISARMING = 3'd4;
    localparam logic [2:0] PHASE_CODE_HALTED    = 3'd5;

    // event kinds
    localparam logic [2:0] FN_UPDATE   = 3'd0;
    localparam logic [2:0] FN_CAL_DONE = 3'd1;
    localparam logic [2:0] FN_ARM_DONE = 3'd2;
    localparam logic [2:0] FN_EXT_STOP = 3'd3;
    localparam logic [2:0] FN_RESTART  = 3'd4;

    // stop codes
    localparam logic [4:0] STOP_NONE     = 5'd0;
    localparam logic [4:0] STOP_IMU      = 5'd1;
    localparam logic [4:0] STOP_TILT     = 5'd2;
    localparam logic [4:0] STOP_EXT_BASE = 5'd3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ARM_DELAY  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOVER_DUR  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TILT_LIMIT = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DISARM_HLD = 4'd3;

    // register reset values
    localparam logic [31:0] ARM_DELAY_RST  = 32'd3000;
    localparam logic [31:0] HOVER_DUR_RST  = 32'd5000;
    localparam logic [14:0] TILT_LIMIT_RST = 15'd5500;
    localparam logic [15:0] DISARM_HLD_RST = 16'd1000;

    typedef struct packed {
        logic [31:0] arm_delay_ms;
        logic [31:0] hover_duration_ms;
        logic [14:0] tilt_limit_cdeg;
        logic [15:0] disarm_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         func;
        logic [31:0]        now_ms;
        logic               imu_healthy;
        logic signed [15:0] roll_cdeg;
        logic signed [15:0] pitch_cdeg;
        logic [3:0]         ext_reason;
    } evt_t;

    // outcome of one event, toward the state and result registers
    typedef struct packed {
        phase_t     phase;
        logic       load_start;
        logic       emergency;
        logic [4:0] stop_code;
        logic       pulse;
    } step_t;

    function automatic logic [2:0] phase_code(phase_t p);
        logic [2:0] code;
        unique case (p)
            PH_BOOT:      code = PHASE_CODE_BOOT;
            PH_READY:     code = PHASE_CODE_READY;
            PH_ARMING:    code = PHASE_CODE_ARMING;
            PH_HOVERING:  code = PHASE_CODE_HOVERING;
            PH_DISARMING: code = PHASE_CODE_DISARMING;
            PH_HALTED:    code = PHASE_CODE_HALTED;
            default:      code = PHASE_CODE_BOOT;
        endcase
        return code;
    endfunction

endpackage

### hw/rtl/fpss_ifs.sv
// ----------------------------------------------------------------------------
// fpss_ifs
// valid/ready channels of the flight phase safety sequencer
// ----------------------------------------------------------------------------
interface fpss_evt_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [31:0]        now_ms;
    logic               imu_healthy;
    logic signed [15:0] roll_cdeg;
    logic signed [15:0] pitch_cdeg;
    logic [3:0]         ext_reason;

    modport source (output valid, func, now_ms, imu_healthy, roll_cdeg, pitch_cdeg,
                    ext_reason, input ready);
    modport sink   (input valid, func, now_ms, imu_healthy, roll_cdeg, pitch_cdeg,
                    ext_reason, output ready);
endinterface

interface fpss_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] phase;
    logic       cut_power;
    logic       emergency;
    logic [4:0] stop_code;
    logic       motors_stop_pulse;

    modport source (output valid, phase, cut_power, emergency, stop_code,
                    motors_stop_pulse, input ready);
    modport sink   (input valid, phase, cut_power, emergency, stop_code,
                    motors_stop_pulse, output ready);
endinterface

interface fpss_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fpss_pkg::CFG_INDEX_W-1:0]   index;
    logic [fpss_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/fpss_cfg_regs.sv
// ----------------------------------------------------------------------------
// fpss_cfg_regs
// timer and tilt limit registers, written over the config channel
// ----------------------------------------------------------------------------
module fpss_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    fpss_cfg_if.sink         cfg,
    output fpss_pkg::cfg_t   regs
);

    fpss_pkg::cfg_t regs_reg;
    fpss_pkg::cfg_t regs_next;
    logic           wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    always_comb
    begin
        regs_next = regs_reg;
        if (wr_en)
        begin
            unique case (cfg.index)
                fpss_pkg::REG_ARM_DELAY:  regs_next.arm_delay_ms      = cfg.data;
                fpss_pkg::REG_HOVER_DUR:  regs_next.hover_duration_ms = cfg.data;
                fpss_pkg::REG_TILT_LIMIT: regs_next.tilt_limit_cdeg   = cfg.data[14:0];
                fpss_pkg::REG_DISARM_HLD: regs_next.disarm_hold_ms    = cfg.data[15:0];
                default:                  regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.arm_delay_ms      <= fpss_pkg::ARM_DELAY_RST;
            regs_reg.hover_duration_ms <= fpss_pkg::HOVER_DUR_RST;
            regs_reg.tilt_limit_cdeg   <= fpss_pkg::TILT_LIMIT_RST;
            regs_reg.disarm_hold_ms    <= fpss_pkg::DISARM_HLD_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

### hw/rtl/fpss_phase_logic.sv
// ----------------------------------------------------------------------------
// fpss_phase_logic
// next phase, emergency latch and stop pulse for one event
// ----------------------------------------------------------------------------
module fpss_phase_logic (
    input  fpss_pkg::evt_t    evt,
    input  fpss_pkg::cfg_t    regs,
    input  fpss_pkg::phase_t  phase,
    input  fpss_pkg::time_t   start_ms,
    input  logic              emergency,
    input  logic [4:0]        stop_code,
    output fpss_pkg::step_t   step
);

    fpss_pkg::time_t          now;
    fpss_pkg::time_t          elapsed;
    logic [fpss_pkg::CMP_W-1:0] elapsed_x;
    logic [15:0]              roll_mag;
    logic [15:0]              pitch_mag;
    logic                     tilt_bad;
    logic                     halt_ok;

    assign now       = fpss_pkg::TIME_W'(evt.now_ms);
    assign elapsed   = now - start_ms;
    assign elapsed_x = fpss_pkg::CMP_W'(elapsed);

    // magnitude of -32768 is 32768, still fits unsigned 16 bits
    assign roll_mag  = evt.roll_cdeg[15]  ? 16'(-evt.roll_cdeg)  : 16'(evt.roll_cdeg);
    assign pitch_mag = evt.pitch_cdeg[15] ? 16'(-evt.pitch_cdeg) : 16'(evt.pitch_cdeg);
    assign tilt_bad  = (roll_mag  > {1'b0, regs.tilt_limit_cdeg}) ||
                       (pitch_mag > {1'b0, regs.tilt_limit_cdeg});

    assign halt_ok   = (phase != fpss_pkg::PH_HALTED);

    always_comb
    begin
        step.phase      = phase;
        step.load_start = 1'b0;
        step.emergency  = emergency;
        step.stop_code  = stop_code;
        step.pulse      = 1'b0;

        unique case (evt.func)
            fpss_pkg::FN_UPDATE:
            begin
                priority if (phase == fpss_pkg::PH_HOVERING && !evt.imu_healthy)
                begin
                    step.phase      = fpss_pkg::PH_HALTED;
                    step.load_start = 1'b1;
                    step.emergency  = 1'b1;
                    step.stop_code  = fpss_pkg::STOP_IMU;
                    step.pulse      = 1'b1;
                end
                else if (phase == fpss_pkg::PH_HOVERING && tilt_bad)
                begin
                    step.phase      = fpss_pkg::PH_HALTED;
                    step.load_start = 1'b1;
                    step.emergency  = 1'b1;
                    step.stop_code  = fpss_pkg::STOP_TILT;
                    step.pulse      = 1'b1;
                end
                else if (phase == fpss_pkg::PH_READY &&
                         elapsed_x >= fpss_pkg::CMP_W'(regs.arm_delay_ms))
                begin
                    step.phase      = fpss_pkg::PH_ARMING;
                    step.load_start = 1'b1;
                end
                else if (phase == fpss_pkg::PH_HOVERING &&
                         elapsed_x >= fpss_pkg::CMP_W'(regs.hover_duration_ms))
                begin
                    step.phase      = fpss_pkg::PH_DISARMING;
                    step.load_start = 1'b1;
                    step.pulse      = 1'b1;
                end
                else if (phase == fpss_pkg::PH_DISARMING &&
                         elapsed_x >= fpss_pkg::CMP_W'(regs.disarm_hold_ms))
                begin
                    step.phase      = fpss_pkg::PH_HALTED;
                    step.load_start = 1'b1;
                end
                else
                begin
                    step.phase      = phase;
                end
            end
            fpss_pkg::FN_CAL_DONE:
            begin
                if (phase == fpss_pkg::PH_BOOT)
                begin
                    step.phase      = fpss_pkg::PH_READY;
                    step.load_start = 1'b1;
                end
            end
            fpss_pkg::FN_ARM_DONE:
            begin
                if (phase == fpss_pkg::PH_ARMING)
                begin
                    step.phase      = fpss_pkg::PH_HOVERING;
                    step.load_start = 1'b1;
                end
            end
            fpss_pkg::FN_EXT_STOP:
            begin
                if (halt_ok)
                begin
                    step.phase      = fpss_pkg::PH_HALTED;
                    step.load_start = 1'b1;
                    step.emergency  = 1'b1;
                    step.stop_code  = fpss_pkg::STOP_EXT_BASE + {1'b0, evt.ext_reason};
                    step.pulse      = 1'b1;
                end
            end
            fpss_pkg::FN_RESTART:
            begin
                step.phase      = fpss_pkg::PH_BOOT;
                step.load_start = 1'b1;
                step.emergency  = 1'b0;
                step.stop_code  = fpss_pkg::STOP_NONE;
            end
            default:
            begin
                step.phase      = phase;
            end
        endcase
    end

endmodule

### hw/rtl/flight_phase_safety_sequencer.sv
// ----------------------------------------------------------------------------
// flight_phase_safety_sequencer
// six-phase flight sequencer with tilt, imu and external emergency stops
// ----------------------------------------------------------------------------
// The sequencer takes one event transaction per clock while the result
// channel is not stalled and returns exactly one status transaction for it,
// in order, through the input register and then the result register. An
// event lands in the input register; the phase logic then works it
// combinationally against the phase, phase start time, emergency latch and
// stop code, and the outcome goes to the state and result registers together.
// The phase-state loop sets the rate at one event per cycle. The result
// register parts the two channels, so a new event is taken while a finished
// status still waits. Elapsed time is now_ms minus the phase start time,
// wrapping at 2^32. Configuration writes take effect on the next clock and
// are meant to be made while no event is in flight; the config channel is
// always ready. Reset puts the block in BOOT with timers at their defaults.
// ----------------------------------------------------------------------------
`include "flight_phase_safety_sequencer_defines.svh"

module flight_phase_safety_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    fpss_evt_if.sink    evt,
    fpss_res_if.source  res,
    fpss_cfg_if.sink    cfg
);

    // ---------------------------------------------------------------- config
    fpss_pkg::cfg_t regs;

    fpss_cfg_regs u_cfg_regs (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .regs (regs)
    );

    // ---------------------------------------------------------- input stage
    logic           evt_valid_reg;
    logic           evt_valid_next;
    fpss_pkg::evt_t evt_reg;
    logic           evt_take;     // input transaction accepted
    logic           stage_adv;    // held event moves into state and result

    logic           res_valid_reg;
    logic           res_valid_next;

    assign stage_adv      = evt_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready      = !evt_valid_reg || stage_adv;
    assign evt_take       = evt.valid && evt.ready;
    assign evt_valid_next = evt_take || (evt_valid_reg && !stage_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            evt_valid_reg <= evt_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            evt_reg.func        <= evt.func;
            evt_reg.now_ms      <= evt.now_ms;
            evt_reg.imu_healthy <= evt.imu_healthy;
            evt_reg.roll_cdeg   <= evt.roll_cdeg;
            evt_reg.pitch_cdeg  <= evt.pitch_cdeg;
            evt_reg.ext_reason  <= evt.ext_reason;
        end
    end

    // ----------------------------------------------------------- phase state
    fpss_pkg::phase_t phase_reg;
    fpss_pkg::phase_t phase_next;
    fpss_pkg::time_t  start_ms_reg;
    fpss_pkg::time_t  start_ms_next;
    logic             emergency_reg;
    logic             emergency_next;
    logic [4:0]       stop_code_reg;
    logic [4:0]       stop_code_next;
    fpss_pkg::step_t  step;

    fpss_phase_logic u_phase_logic (
        .evt      (evt_reg),
        .regs     (regs),
        .phase    (phase_reg),
        .start_ms (start_ms_reg),
        .emergency(emergency_reg),
        .stop_code(stop_code_reg),
        .step     (step)
    );

    // every phase entry restarts the phase timer at the event's time
    always_comb
    begin
        phase_next     = phase_reg;
        start_ms_next  = start_ms_reg;
        emergency_next = emergency_reg;
        stop_code_next = stop_code_reg;
        if (stage_adv)
        begin
            phase_next     = step.phase;
            emergency_next = step.emergency;
            stop_code_next = step.stop_code;
            if (step.load_start)
            begin
                start_ms_next = fpss_pkg::TIME_W'(evt_reg.now_ms);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= fpss_pkg::PH_BOOT;
            start_ms_reg  <= '0;
            emergency_reg <= 1'b0;
            stop_code_reg <= fpss_pkg::STOP_NONE;
        end
        else
        begin
            phase_reg     <= phase_next;
            start_ms_reg  <= start_ms_next;
            emergency_reg <= emergency_next;
            stop_code_reg <= stop_code_next;
        end
    end

    // --------------------------------------------------------- result stage
    logic [2:0] res_phase_reg;
    logic       res_cut_reg;
    logic       res_emerg_reg;
    logic [4:0] res_code_reg;
    logic       res_pulse_reg;

    assign res_valid_next = stage_adv || (res_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // status shows the state after the event
    always_ff @(posedge clk)
    begin
        if (stage_adv)
        begin
            res_phase_reg <= fpss_pkg::phase_code(step.phase);
            res_cut_reg   <= step.emergency || (step.phase != fpss_pkg::PH_HOVERING);
            res_emerg_reg <= step.emergency;
            res_code_reg  <= step.stop_code;
            res_pulse_reg <= step.pulse;
        end
    end

    assign res.valid             = res_valid_reg;
    assign res.phase             = res_phase_reg;
    assign res.cut_power         = res_cut_reg;
    assign res.emergency         = res_emerg_reg;
    assign res.stop_code         = res_code_reg;
    assign res.motors_stop_pulse = res_pulse_reg;

    // ----------------------------------------------------------- assertions
    // phase register stays one-hot
    `FPSS_ASSERT_ALWAYS(a_phase_onehot, clk, rst_n, $onehot(phase_reg))
    // a latched emergency only ever sits in halted
    `FPSS_ASSERT_ALWAYS(a_emerg_halted, clk, rst_n, !emergency_reg || (phase_reg == fpss_pkg::PH_HALTED))
    // a stop code is kept exactly while the emergency is latched
    `FPSS_ASSERT_ALWAYS(a_code_matches, clk, rst_n, (stop_code_reg != fpss_pkg::STOP_NONE) == emergency_reg)
    // a stop pulse leaves the block in disarming or halted
    `FPSS_ASSERT_ALWAYS(a_pulse_phase, clk, rst_n, !(res_valid_reg && res_pulse_reg) || (res_phase_reg == fpss_pkg::PHASE_CODE_DISARMING) || (res_phase_reg == fpss_pkg::PHASE_CODE_HALTED))
    // an advancing event always yields a pending result
    `FPSS_ASSERT_NEXT(a_adv_result, clk, rst_n, stage_adv, res_valid_reg)

endmodule
